@@ src/mvls_pkg.sv @@
package mvls_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_SEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_SEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE    = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [7:0] PAIR_SEP_RST  = 8'd58;
    localparam logic [7:0] ENTRY_SEP_RST = 8'd59;
    localparam logic [7:0] ESCAPE_RST    = 8'd92;

    // Result classes.
    localparam logic [2:0] CLS_NONE   = 3'd0;
    localparam logic [2:0] CLS_MARKER = 3'd1;
    localparam logic [2:0] CLS_VALUE  = 3'd2;
    localparam logic [2:0] CLS_ENTRY  = 3'd3;
    localparam logic [2:0] CLS_ERROR  = 3'd4;

    // Queue between the front and the back part.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // One classified byte as it travels through the queue.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       line_last;
        logic       is_escape;
        logic       is_pair;
        logic       is_entry;
    } t_item;

endpackage

@@ src/mvls_front.sv @@
module mvls_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mvls_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data,
    input  logic [7:0]                    i_text_byte,
    input  logic                          i_line_last,
    output mvls_pkg::t_item               o_item
);

    logic [7:0] r_pair_sep;
    logic [7:0] r_entry_sep;
    logic [7:0] r_escape;

    // The register port never waits.
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_sep  <= mvls_pkg::PAIR_SEP_RST;
            r_entry_sep <= mvls_pkg::ENTRY_SEP_RST;
            r_escape    <= mvls_pkg::ESCAPE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mvls_pkg::REG_PAIR_SEP:  r_pair_sep  <= i_cfg_data;
                mvls_pkg::REG_ENTRY_SEP: r_entry_sep <= i_cfg_data;
                mvls_pkg::REG_ESCAPE:    r_escape    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Classify the incoming byte against the three special bytes.
    always_comb begin
        o_item.text_byte = i_text_byte;
        o_item.line_last = i_line_last;
        o_item.is_escape = (i_text_byte == r_escape);
        o_item.is_pair   = (i_text_byte == r_pair_sep);
        o_item.is_entry  = (i_text_byte == r_entry_sep);
    end

endmodule

@@ src/mvls_queue.sv @@
module mvls_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mvls_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output mvls_pkg::t_item o_item
);

    mvls_pkg::t_item                 r_slot [mvls_pkg::QUEUE_DEPTH];
    logic [mvls_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [mvls_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [mvls_pkg::QCNT_W-1:0]     r_count;
    logic [mvls_pkg::QCNT_W-1:0]     n_count;

    assign o_full  = (r_count == mvls_pkg::QCNT_W'(mvls_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // Storage slots.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

@@ src/mvls_back.sv @@
module mvls_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_item_valid,
    input  mvls_pkg::t_item i_item,
    output logic            o_item_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [2:0]      o_byte_class,
    output logic [7:0]      o_out_byte,
    output logic            o_line_end,
    output logic            o_line_ok
);

    typedef enum logic [1:0] {
        MODE_MARKER = 2'd0,
        MODE_VALUE  = 2'd1,
        MODE_ERROR  = 2'd2,
        MODE_DROP   = 2'd3
    } t_mode;

    localparam logic [1:0] ESC_SPAN = 2'd2;

    t_mode      r_mode;
    t_mode      n_mode;
    logic [1:0] r_esc_left;
    logic [1:0] n_esc_left;
    logic       r_line_bad;
    logic       n_line_bad;
    logic       r_out_valid;
    logic [2:0] r_class;
    logic [2:0] n_class;
    logic [7:0] r_byte;
    logic [7:0] n_byte;
    logic       r_end;
    logic       r_ok;
    logic       n_ok;
    logic [1:0] esc_dec;
    logic [1:0] esc_upd;
    logic       open;
    logic       take;

    // A byte is taken whenever the output register is free or being drained.
    assign take       = i_item_valid && (!r_out_valid || !i_out_stall);
    assign o_item_pop = take;

    // The shield countdown is decremented before the escape test.
    always_comb begin
        esc_dec = (r_esc_left != 2'd0) ? (r_esc_left - 2'd1) : 2'd0;
        esc_upd = (i_item.is_escape && esc_dec == 2'd0) ? ESC_SPAN : esc_dec;
        open    = (esc_upd == 2'd0);
    end

    // Parse step for one byte.
    always_comb begin
        n_mode     = r_mode;
        n_esc_left = r_esc_left;
        n_line_bad = r_line_bad;
        n_class    = mvls_pkg::CLS_NONE;
        n_byte     = 8'd0;
        case (r_mode)
            MODE_MARKER: begin
                n_esc_left = esc_upd;
                if (open && i_item.is_entry) begin
                    n_mode = MODE_ERROR;
                end else if (open && i_item.is_pair) begin
                    n_mode = MODE_VALUE;
                end else begin
                    n_class = mvls_pkg::CLS_MARKER;
                    n_byte  = i_item.text_byte;
                end
            end
            MODE_VALUE: begin
                n_esc_left = esc_upd;
                if (open && i_item.is_pair) begin
                    n_mode = MODE_ERROR;
                end else if ((open && i_item.is_entry) || i_item.line_last) begin
                    n_class = mvls_pkg::CLS_ENTRY;
                    n_mode  = MODE_MARKER;
                end else begin
                    n_class = mvls_pkg::CLS_VALUE;
                    n_byte  = i_item.text_byte;
                end
            end
            MODE_ERROR: begin
                n_class    = mvls_pkg::CLS_ERROR;
                n_line_bad = 1'b1;
                n_mode     = MODE_DROP;
            end
            default: begin
            end
        endcase
        n_ok = i_item.line_last && !n_line_bad;
        // Every line starts from a clean state.
        if (i_item.line_last) begin
            n_mode     = MODE_MARKER;
            n_esc_left = 2'd0;
            n_line_bad = 1'b0;
        end
    end

    // Parser state and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_MARKER;
            r_esc_left  <= 2'd0;
            r_line_bad  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_mode     <= n_mode;
                r_esc_left <= n_esc_left;
                r_line_bad <= n_line_bad;
                r_class    <= n_class;
                r_byte     <= n_byte;
                r_end      <= i_item.line_last;
                r_ok       <= n_ok;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_byte_class = r_class;
    assign o_out_byte   = r_byte;
    assign o_line_end   = r_end;
    assign o_line_ok    = r_ok;

endmodule

@@ src/marker_value_line_splitter.sv @@
// Marker/value line splitter.
// Input channel: i_in_valid / o_in_stall carry one byte of a text line per
// transaction (i_text_byte) with i_line_last marking the final byte.
// Output channel: o_out_valid / i_out_stall carry exactly one result per input
// byte: a class (marker char, value char, entry complete, none for a separator
// or dropped byte, line error), the byte itself for character classes, the line
// end echo and, at line end, whether the line was free of flagged errors.
// Register port: i_cfg_valid / o_cfg_ready with i_cfg_index selecting the pair
// separator (0), entry separator (1) or escape byte (2); o_cfg_ready is always
// high. Write registers only while no bytes are in flight.
// Throughput is one byte per cycle while the receiver does not stall. Each byte
// is first written into the four-entry queue, then the parser writes its result
// into its output register.
// When the receiver stalls, the result holds and the queue absorbs up to four
// more bytes before o_in_stall rises.
// Reset (synchronous, active low) restores the default separators and
// empties the queue, the parser state and the output register.
module marker_value_line_splitter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mvls_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_text_byte,
    input  logic                           i_line_last,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [2:0]                     o_byte_class,
    output logic [7:0]                     o_out_byte,
    output logic                           o_line_end,
    output logic                           o_line_ok
);

    mvls_pkg::t_item front_item;
    mvls_pkg::t_item queue_item;
    logic            queue_full;
    logic            queue_valid;
    logic            queue_pop;
    logic            push;

    assign o_in_stall = queue_full;
    assign push       = i_in_valid && !queue_full;

    // Front part: configuration and byte classification.
    mvls_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_text_byte (i_text_byte),
        .i_line_last (i_line_last),
        .o_item      (front_item)
    );

    // Short queue decoupling the two parts.
    mvls_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_item  (queue_item)
    );

    // Back part: parser state machine and output register.
    mvls_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (queue_valid),
        .i_item       (queue_item),
        .o_item_pop   (queue_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_byte_class (o_byte_class),
        .o_out_byte   (o_out_byte),
        .o_line_end   (o_line_end),
        .o_line_ok    (o_line_ok)
    );

endmodule

@@ src/mvls_checker.sv @@
module mvls_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_byte_class,
    input logic [7:0] o_out_byte,
    input logic       o_line_end,
    input logic       o_line_ok
);

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // Only the defined classes appear.
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_byte_class <= mvls_pkg::CLS_ERROR)
        else $error("undefined result class");

    // Non-character classes carry a zero byte.
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_class != mvls_pkg::CLS_MARKER
            && o_byte_class != mvls_pkg::CLS_VALUE |-> o_out_byte == 8'd0)
        else $error("byte set on a non-character class");

    // Line status is reported only at the end of a line.
    a_ok_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_line_ok |-> o_line_end)
        else $error("line status outside line end");

    // A flagged error on the final byte makes the line bad.
    a_err_not_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_line_end && o_byte_class == mvls_pkg::CLS_ERROR
            |-> !o_line_ok)
        else $error("flagged line reported as good");

endmodule

bind marker_value_line_splitter mvls_checker u_mvls_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_byte_class (o_byte_class),
    .o_out_byte   (o_out_byte),
    .o_line_end   (o_line_end),
    .o_line_ok    (o_line_ok)
);
